/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define DWTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DWTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/dwtc_pkg.sv */
package dwtc_pkg;

  // field widths
  localparam int ADDR_W    = 12;
  localparam int DAC_W     = 10;
  localparam int IDX_W     = 4;
  localparam int TOTAL_W   = 32;
  localparam int WARN_W    = 2;
  localparam int COUNT_W   = 5;
  localparam int WORD_W    = 64;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [DAC_W-1:0]   dac_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [NIB_W-1:0]   nib_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 3'd0,
    CFG_REGION_END   = 3'd1,
    CFG_LUT_COUNT    = 3'd2,
    CFG_LUT_TIME     = 3'd3,
    CFG_LUT_BOOST    = 3'd4,
    CFG_LUT_REPEAT   = 3'd5
  } cfg_reg_t;

  // warning codes
  typedef enum logic [WARN_W-1:0] {
    WARN_NONE         = 2'd0,
    WARN_HIGH_VOLTAGE = 2'd1,
    WARN_LOW_VOLTAGE  = 2'd2,
    WARN_LOW_CURRENT  = 2'd3
  } warn_t;

  // default table indexes for the first entry of a list
  localparam idx_t DEFAULT_VOLTAGE_INDEX = 4'd2;
  localparam idx_t DEFAULT_CURRENT_INDEX = 4'd9;
  localparam dac_t DAC_MAX               = 10'd1023;

  // write-time exponents
  localparam nib_t EXP_SETTLE_FROM_ZERO = 4'd11;
  localparam nib_t EXP_SETTLE_TINY      = 4'd13;
  localparam nib_t EXP_LOW              = 4'd9;
  localparam nib_t EXP_MID              = 4'd7;
  localparam nib_t EXP_HIGH             = 4'd5;
  localparam nib_t EXP_HIGH_BIG_STEP    = 4'd11;

  // value bands and step limits
  localparam dac_t VALUE_TINY = 10'd15;
  localparam dac_t VALUE_LOW  = 10'd100;
  localparam dac_t VALUE_MID  = 10'd300;
  localparam dac_t VALUE_HIGH = 10'd600;
  localparam dac_t STEP_MID   = 10'd300;
  localparam dac_t STEP_BIG   = 10'd512;

  // warning thresholds
  localparam int     CYCLES_PER_MS = 100 * 1000;
  localparam total_t LIMIT_LONG    = TOTAL_W'(8 * CYCLES_PER_MS);
  localparam total_t LIMIT_SHORT   = TOTAL_W'(2 * CYCLES_PER_MS);
  localparam dac_t   HIGH_VOLTAGE  = 10'd600;
  localparam dac_t   LOW_VOLTAGE   = 10'd50;
  localparam dac_t   LOW_CURRENT   = 10'd100;

endpackage

/* rtl/core/dwtc_if.sv */
// parameter entry channel
interface dwtc_in_if import dwtc_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t param_address;
  dac_t  dac_value;
  logic  first_entry;

  modport source (output valid, output param_address, output dac_value,
                  output first_entry, input ready);
  modport sink   (input valid, input param_address, input dac_value,
                  input first_entry, output ready);
endinterface

// timing result channel
interface dwtc_out_if import dwtc_pkg::*; ();
  logic              valid;
  logic              ready;
  idx_t              lut_index;
  logic              not_found;
  logic              is_voltage;
  total_t            cycle_total;
  logic [WARN_W-1:0] warning;

  modport source (output valid, output lut_index, output not_found,
                  output is_voltage, output cycle_total, output warning,
                  input ready);
  modport sink   (input valid, input lut_index, input not_found,
                  input is_voltage, input cycle_total, input warning,
                  output ready);
endinterface

/* rtl/core/dac_write_timing_checker.sv */
// a result beat is valid in the cycle after its entry beat is accepted
// throughput: one entry per cycle while the result is not stalled; the running totals, min/max and previous
// value are updated in the same cycle the entry is accepted
// a new entry is taken while the result register is empty or being emptied
// reset (synchronous, active high) clears configuration, totals and result valid
module dac_write_timing_checker
  import dwtc_pkg::*;
#(
  parameter int LUT_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data,
  dwtc_in_if.sink              items,
  dwtc_out_if.source           results
);

  // configuration registers
  addr_t  region_start;
  addr_t  region_end;
  count_t lut_count;
  word_t  lut_time;
  word_t  lut_boost;
  word_t  lut_repeat;

  // running state
  dac_t   previous_value;
  total_t cycle_sum;
  dac_t   max_voltage;
  dac_t   min_voltage;
  dac_t   max_current;
  dac_t   min_current;

  // result register
  logic   out_valid;
  idx_t   out_index;
  logic   out_not_found;
  logic   out_voltage;
  total_t out_total;
  warn_t  out_warning;

  // per-beat logic
  logic                  accept;
  logic                  is_volt;
  dac_t                  step;
  nib_t                  expo;
  count_t                limit;
  logic                  hit;
  idx_t                  hit_index;
  nib_t                  time_exp;
  nib_t                  boost_exp;
  nib_t                  repeat_fac;
  logic [16:0]           pair_cycles;
  logic [20:0]           add_cycles;
  logic [TOTAL_W:0]      sum_wide;
  total_t                cycle_sum_next;
  dac_t                  max_voltage_next;
  dac_t                  min_voltage_next;
  dac_t                  max_current_next;
  dac_t                  min_current_next;
  idx_t                  index_next;
  logic                  not_found_next;
  warn_t                 warning_next;

  function automatic nib_t pick_exponent(input dac_t value, input dac_t prev,
                                         input dac_t diff);
    nib_t e;
    if (value < VALUE_TINY) begin
      e = (prev == '0) ? EXP_SETTLE_FROM_ZERO : EXP_SETTLE_TINY;
    end else if (value < VALUE_LOW) begin
      e = EXP_LOW;
    end else if (value < VALUE_MID) begin
      e = EXP_MID;
    end else if (value < VALUE_HIGH) begin
      e = (diff > STEP_MID) ? EXP_LOW : EXP_MID;
    end else begin
      e = (diff <= STEP_BIG) ? EXP_HIGH : EXP_HIGH_BIG_STEP;
    end
    return e;
  endfunction

  // handshake
  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;

  // classification and exponent choice
  always_comb begin
    is_volt = (items.param_address >= region_start) &&
              (items.param_address < region_end) &&
              !items.param_address[0];
    step = (items.dac_value >= previous_value) ? (items.dac_value - previous_value)
                                               : (previous_value - items.dac_value);
    expo  = pick_exponent(items.dac_value, previous_value, step);
    limit = (lut_count > COUNT_W'(LUT_ENTRIES)) ? COUNT_W'(LUT_ENTRIES) : lut_count;
  end

  // parallel table compare, lowest matching entry wins
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = LUT_ENTRIES - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < limit) &&
          ((is_volt ? lut_time[i*NIB_W +: NIB_W] : lut_boost[i*NIB_W +: NIB_W]) == expo)) begin
        hit       = 1'b1;
        hit_index = IDX_W'(i);
      end
    end
  end

  // refresh cycles of the chosen entry and saturating total
  always_comb begin
    time_exp    = lut_time[hit_index*NIB_W +: NIB_W];
    boost_exp   = lut_boost[hit_index*NIB_W +: NIB_W];
    repeat_fac  = lut_repeat[hit_index*NIB_W +: NIB_W];
    if (repeat_fac == '0) begin
      repeat_fac = 4'd1;
    end
    pair_cycles = (17'd1 << time_exp) + (17'd1 << boost_exp);
    add_cycles  = 21'(pair_cycles) * 21'(repeat_fac);
    sum_wide    = {1'b0, cycle_sum} + (TOTAL_W+1)'(add_cycles);
  end

  // next totals and result fields
  always_comb begin
    cycle_sum_next   = cycle_sum;
    max_voltage_next = max_voltage;
    min_voltage_next = min_voltage;
    max_current_next = max_current;
    min_current_next = min_current;
    index_next       = '0;
    not_found_next   = 1'b0;
    if (items.first_entry) begin
      cycle_sum_next   = '0;
      max_voltage_next = '0;
      min_voltage_next = DAC_MAX;
      max_current_next = '0;
      min_current_next = DAC_MAX;
      index_next       = is_volt ? DEFAULT_VOLTAGE_INDEX : DEFAULT_CURRENT_INDEX;
    end else begin
      if (is_volt) begin
        if (items.dac_value > max_voltage) max_voltage_next = items.dac_value;
        if (items.dac_value < min_voltage) min_voltage_next = items.dac_value;
      end else begin
        if (items.dac_value > max_current) max_current_next = items.dac_value;
        if (items.dac_value < min_current) min_current_next = items.dac_value;
      end
      if (hit) begin
        index_next     = hit_index;
        cycle_sum_next = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
      end else begin
        not_found_next = 1'b1;
      end
    end
    // warning from the updated totals
    priority if ((cycle_sum_next > LIMIT_LONG) && (max_voltage_next >= HIGH_VOLTAGE)) begin
      warning_next = WARN_HIGH_VOLTAGE;
    end else if ((cycle_sum_next > LIMIT_SHORT) && (min_voltage_next < LOW_VOLTAGE)) begin
      warning_next = WARN_LOW_VOLTAGE;
    end else if ((cycle_sum_next > LIMIT_LONG) && (min_current_next < LOW_CURRENT)) begin
      warning_next = WARN_LOW_CURRENT;
    end else begin
      warning_next = WARN_NONE;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_start <= '0;
      region_end   <= '0;
      lut_count    <= '0;
      lut_time     <= '0;
      lut_boost    <= '0;
      lut_repeat   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REGION_START: region_start <= cfg_data[ADDR_W-1:0];
        CFG_REGION_END:   region_end   <= cfg_data[ADDR_W-1:0];
        CFG_LUT_COUNT:    lut_count    <= cfg_data[COUNT_W-1:0];
        CFG_LUT_TIME:     lut_time     <= cfg_data;
        CFG_LUT_BOOST:    lut_boost    <= cfg_data;
        CFG_LUT_REPEAT:   lut_repeat   <= cfg_data;
        default: ;
      endcase
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_value <= '0;
      cycle_sum      <= '0;
      max_voltage    <= '0;
      min_voltage    <= DAC_MAX;
      max_current    <= '0;
      min_current    <= DAC_MAX;
    end else if (accept) begin
      previous_value <= items.dac_value;
      cycle_sum      <= cycle_sum_next;
      max_voltage    <= max_voltage_next;
      min_voltage    <= min_voltage_next;
      max_current    <= max_current_next;
      min_current    <= min_current_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (items.ready) begin
      out_valid <= items.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_index     <= index_next;
      out_not_found <= not_found_next;
      out_voltage   <= is_volt;
      out_total     <= cycle_sum_next;
      out_warning   <= warning_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.lut_index   = out_index;
  assign results.not_found   = out_not_found;
  assign results.is_voltage  = out_voltage;
  assign results.cycle_total = out_total;
  assign results.warning     = out_warning;

endmodule

/* rtl/core/dwtc_checker.sv */
`include "assert_macros.svh"

module dwtc_checker
  import dwtc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              first_entry,
  input logic              out_valid,
  input logic              out_ready,
  input logic              not_found,
  input total_t            cycle_total,
  input logic [WARN_W-1:0] warning
);

  // a stalled result beat keeps its payload
  `DWTC_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(cycle_total) && $stable(warning), "stalled result changed")

  // every accepted entry gives a result on the next cycle
  `DWTC_ASSERT(a_latency, clk, rst, in_valid && in_ready |=> out_valid, "result missing after accepted entry")

  // an empty result register never blocks the input
  `DWTC_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready, "input blocked with empty output")

  // a first entry starts a fresh list with a clean total
  `DWTC_ASSERT(a_first_clears, clk, rst, in_valid && in_ready && first_entry |=> cycle_total == '0 && !not_found && warning == WARN_NONE, "first entry did not clear totals")

endmodule

bind dac_write_timing_checker dwtc_checker u_dwtc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .first_entry (items.first_entry),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .not_found   (results.not_found),
  .cycle_total (results.cycle_total),
  .warning     (results.warning)
);
